>>> hdl/urt_pkg.sv
// types, constants and codes shared by the user record table and its cells
package urt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NAME_BYTES    = 8;
    localparam int KEY_BYTES     = 8;

    localparam int FIELD_W   = 64;
    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int IN_DATA_W  = 328;
    localparam int OUT_DATA_W = 272;

    localparam logic [FIELD_W-1:0] NAME_MASK = {FIELD_W{1'b1}} >> (FIELD_W - 8 * NAME_BYTES);
    localparam logic [FIELD_W-1:0] KEY_MASK  = {FIELD_W{1'b1}} >> (FIELD_W - 8 * KEY_BYTES);

    localparam logic [OP_W-1:0] OP_ADD         = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND_NAME   = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND_KEY    = 3'd2;
    localparam logic [OP_W-1:0] OP_RENAME_NAME = 3'd3;
    localparam logic [OP_W-1:0] OP_RENAME_KEY  = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE_NAME = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTED   = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0]        name;
        logic [FIELD_W-1:0]        key;
        logic signed [FIELD_W-1:0] start_time;
        logic signed [FIELD_W-1:0] end_time;
        logic                      admin;
    } rec_t;

    // query broadcast to every cell
    typedef struct packed {
        logic [FIELD_W-1:0] name;
        logic [FIELD_W-1:0] key;
        logic               by_key;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   last;
    } qry_t;

    // write command broadcast to every cell
    typedef struct packed {
        logic             wr_rec;
        logic             wr_name;
        logic             clr;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] last;
        rec_t             rec;
    } wr_t;

    // first-match selection passed from cell to cell
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] slot;
        rec_t             rec;
    } sel_t;

endpackage

>>> hdl/user_record_table.sv
// user record table top level: request sequencer, row of record cells, result register
//
// A request passes through the states idle, in which it is accepted; compare, in which every
// cell compares its record with the query; select, in which the chain of cells picks the lowest
// live match (and, for delete, the last live entry); and update, which writes the table and loads
// the result register once any earlier result has been taken. The next request is taken once
// the update is done, even while the result still waits for m_tready; a waiting result holds
// back only the write of the following request. Reset clears all records and the count at once.
module user_record_table
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // user_name, replacement_name, access_key, start_time, end_time, admin_flag
    input  logic [urt_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic [urt_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // record_name, record_key, record_start, record_end, record_admin, record_slot,
    // live_count
    output logic [urt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [urt_pkg::STATUS_W-1:0]      m_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam int N = urt_pkg::TABLE_ENTRIES;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [urt_pkg::CNT_W-1:0]    count_reg;
    logic [urt_pkg::CNT_W-1:0]    count_next;

    logic [urt_pkg::OP_W-1:0]     op_reg;
    logic [urt_pkg::FIELD_W-1:0]  name_reg;
    logic [urt_pkg::FIELD_W-1:0]  newname_reg;
    urt_pkg::rec_t                new_rec_reg;

    logic                         hit_reg;
    logic [urt_pkg::IDX_W-1:0]    hit_slot_reg;
    urt_pkg::rec_t                hit_rec_reg;
    urt_pkg::rec_t                last_rec_reg;

    logic                         m_valid_reg;
    logic [urt_pkg::STATUS_W-1:0] out_status_reg;
    urt_pkg::rec_t                out_rec_reg;
    logic [urt_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [urt_pkg::COUNT_W-1:0]  out_count_reg;

    logic                         accept;
    logic                         fire;
    urt_pkg::qry_t                qry;
    urt_pkg::wr_t                 wr_cmd;
    urt_pkg::wr_t                 wr;
    logic [urt_pkg::STATUS_W-1:0] res_status;
    urt_pkg::rec_t                res_rec;
    logic [urt_pkg::IDX_W-1:0]    res_slot;

    urt_pkg::sel_t                sel_chain [0:N];
    urt_pkg::rec_t                last_chain [0:N];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == S_UPD) && (!m_valid_reg || m_tready);

    always_comb
    begin
        qry.name   = name_reg;
        qry.key    = new_rec_reg.key;
        qry.by_key = (op_reg == urt_pkg::OP_FIND_KEY) || (op_reg == urt_pkg::OP_RENAME_KEY);
        qry.count  = count_reg;
        qry.last   = urt_pkg::IDX_W'(count_reg - urt_pkg::CNT_W'(1));
    end

    assign sel_chain[0]  = '0;
    assign last_chain[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        urt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (urt_pkg::IDX_W'(i)),
            .qry      (qry),
            .wr       (wr),
            .sel_in   (sel_chain[i]),
            .sel_out  (sel_chain[i+1]),
            .last_in  (last_chain[i]),
            .last_out (last_chain[i+1])
        );
    end

    // result and table update decided in the write cycle
    always_comb
    begin
        res_status = urt_pkg::ST_NOT_FOUND;
        res_rec    = '0;
        res_slot   = '0;
        wr_cmd     = '0;
        count_next = count_reg;
        case (op_reg)
            urt_pkg::OP_ADD:
            begin
                if (hit_reg)
                begin
                    res_status = urt_pkg::ST_EXISTED;
                    res_rec    = hit_rec_reg;
                    res_slot   = hit_slot_reg;
                end
                else if (count_reg == urt_pkg::CNT_W'(N))
                begin
                    res_status = urt_pkg::ST_FULL;
                end
                else
                begin
                    res_status    = urt_pkg::ST_OK;
                    res_rec       = new_rec_reg;
                    res_rec.name  = name_reg;
                    res_slot      = urt_pkg::IDX_W'(count_reg);
                    wr_cmd.wr_rec = 1'b1;
                    wr_cmd.slot   = urt_pkg::IDX_W'(count_reg);
                    wr_cmd.rec    = res_rec;
                    count_next    = count_reg + urt_pkg::CNT_W'(1);
                end
            end
            urt_pkg::OP_FIND_NAME, urt_pkg::OP_FIND_KEY:
            begin
                if (hit_reg)
                begin
                    res_status = urt_pkg::ST_OK;
                    res_rec    = hit_rec_reg;
                    res_slot   = hit_slot_reg;
                end
            end
            urt_pkg::OP_RENAME_NAME, urt_pkg::OP_RENAME_KEY:
            begin
                if (hit_reg)
                begin
                    res_status     = urt_pkg::ST_OK;
                    res_rec        = hit_rec_reg;
                    res_rec.name   = newname_reg;
                    res_slot       = hit_slot_reg;
                    wr_cmd.wr_name = 1'b1;
                    wr_cmd.slot    = hit_slot_reg;
                    wr_cmd.rec     = res_rec;
                end
            end
            urt_pkg::OP_DELETE_NAME:
            begin
                if (hit_reg)
                begin
                    res_status    = urt_pkg::ST_OK;
                    res_rec       = hit_rec_reg;
                    res_slot      = hit_slot_reg;
                    // the last entry moves into the freed slot and the last slot is cleared
                    wr_cmd.wr_rec = 1'b1;
                    wr_cmd.clr    = 1'b1;
                    wr_cmd.slot   = hit_slot_reg;
                    wr_cmd.last   = qry.last;
                    wr_cmd.rec    = last_rec_reg;
                    count_next    = count_reg - urt_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                res_status = urt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        wr = wr_cmd;
        if (!fire)
        begin
            wr.wr_rec  = 1'b0;
            wr.wr_name = 1'b0;
            wr.clr     = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg                 <= s_tuser;
            name_reg               <= s_tdata[63:0] & urt_pkg::NAME_MASK;
            newname_reg            <= s_tdata[127:64] & urt_pkg::NAME_MASK;
            new_rec_reg.name       <= s_tdata[63:0] & urt_pkg::NAME_MASK;
            new_rec_reg.key        <= s_tdata[191:128] & urt_pkg::KEY_MASK;
            new_rec_reg.start_time <= s_tdata[255:192];
            new_rec_reg.end_time   <= s_tdata[319:256];
            new_rec_reg.admin      <= s_tdata[320];
        end
        if (state_reg == S_SEL)
        begin
            hit_reg      <= sel_chain[N].hit;
            hit_slot_reg <= sel_chain[N].slot;
            hit_rec_reg  <= sel_chain[N].rec;
            last_rec_reg <= last_chain[N];
        end
        if (fire)
        begin
            out_status_reg <= res_status;
            out_rec_reg    <= res_rec;
            out_slot_reg   <= urt_pkg::SLOT_W'(res_slot);
            out_count_reg  <= urt_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_slot_reg, out_rec_reg.admin,
                       out_rec_reg.end_time, out_rec_reg.start_time,
                       out_rec_reg.key, out_rec_reg.name};

endmodule

>>> hdl/urt_cell.sv
// one table slot: holds a record, matches the query and joins the selection chain
module urt_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [urt_pkg::IDX_W-1:0] index,
    input  urt_pkg::qry_t    qry,
    input  urt_pkg::wr_t     wr,
    input  urt_pkg::sel_t    sel_in,
    output urt_pkg::sel_t    sel_out,
    input  urt_pkg::rec_t    last_in,
    output urt_pkg::rec_t    last_out
);

    urt_pkg::rec_t rec_reg;
    urt_pkg::rec_t rec_next;
    logic          match_reg;
    logic          match_next;
    logic          live;

    assign live = urt_pkg::CNT_W'(index) < qry.count;

    always_comb
    begin
        match_next = live && (qry.by_key ? (rec_reg.key == qry.key)
                                         : (rec_reg.name == qry.name));
    end

    always_comb
    begin
        rec_next = rec_reg;
        if (wr.clr && (index == wr.last))
        begin
            rec_next = '0;
        end
        else if (wr.wr_rec && (index == wr.slot))
        begin
            rec_next = wr.rec;
        end
        else if (wr.wr_name && (index == wr.slot))
        begin
            rec_next.name = wr.rec.name;
        end
    end

    // lowest index wins: pass on what came from below once a hit is seen
    always_comb
    begin
        sel_out = sel_in;
        if (!sel_in.hit && match_reg)
        begin
            sel_out.hit  = 1'b1;
            sel_out.slot = index;
            sel_out.rec  = rec_reg;
        end
    end

    assign last_out = (index == qry.last) ? rec_reg : last_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            rec_reg   <= rec_next;
            match_reg <= match_next;
        end
    end

endmodule
